### src/itora_pkg.sv
// itora_pkg: shared constants, command/status structs, controller states and the
// digit-to-character function of the integer to radix text converter
// no dependencies
package itora_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int NUMBER_BITS = 32;
   localparam int CHUNK_BITS  = 8;
   localparam int CHUNKS      = VALUE_BITS / CHUNK_BITS;
   localparam int STEP_BITS   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int CNT_BITS    = $clog2(VALUE_BITS + 1);
   localparam int ADDR_BITS   = $clog2(VALUE_BITS);
   localparam int DIGIT_BITS  = 6;
   localparam int CHAR_BITS   = 7;
   localparam int RADIX_BITS  = 6;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(36);
   localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);

   // register index, taken from paddr above the byte offset
   localparam logic [CSR_ADDR_BITS-3:0] REG_RADIX = '0;

   localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 7'h2d;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 7'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_NULL    = 7'h00;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_READ,
      ST_EMIT,
      ST_BAD
   } itora_state_type;

   typedef struct packed {
      logic load;       // capture a new number
      logic div_step;   // one chunk of long division
      logic div_last;   // final chunk: push the remainder digit
      logic rd;         // read next digit from the stack
      logic out_sign;   // load '-' into the output register
      logic out_digit;  // load a digit character
      logic out_bad;    // load the error word
   } itora_cmd_type;

   typedef struct packed {
      logic radix_bad;
      logic quot_zero;
      logic negative;
      logic cnt_zero;
      logic out_free;
   } itora_sts_type;

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] c;
      if (d < DIGIT_BITS'(10)) begin
         c = CHAR_ZERO + CHAR_BITS'(d);
      end else begin
         c = CHAR_LOWER_A + CHAR_BITS'(d - DIGIT_BITS'(10));
      end
      return c;
   endfunction

endpackage

### src/itora_if.sv
// itora_req_if / itora_rsp_if: valid/ready channels of the converter
// depends on itora_pkg for field widths
interface itora_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [itora_pkg::NUMBER_BITS-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface itora_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [itora_pkg::CHAR_BITS-1:0]  character;
   logic                             is_last;
   logic                             bad_radix;

   modport source (output valid, output character, output is_last, output bad_radix,
                   input ready);
   modport sink   (input valid, input character, input is_last, input bad_radix,
                   output ready);
endinterface

### src/itora_ctrl.sv
// itora_ctrl: sequencer of the converter, drives datapath commands
// depends on itora_pkg
module itora_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  itora_pkg::itora_sts_type sts,
   output itora_pkg::itora_cmd_type cmd
);

   itora_pkg::itora_state_type        state_ff, state_in;
   logic [itora_pkg::STEP_BITS-1:0]   step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itora_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         itora_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (sts.radix_bad) begin
                  state_in = itora_pkg::ST_BAD;
               end else begin
                  cmd.load = 1'b1;
                  step_in  = '0;
                  state_in = itora_pkg::ST_DIVIDE;
               end
            end
         end
         itora_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == itora_pkg::STEP_BITS'(itora_pkg::CHUNKS - 1)) begin
               cmd.div_last = 1'b1;
               step_in      = '0;
               if (sts.quot_zero) begin
                  state_in = sts.negative ? itora_pkg::ST_SIGN : itora_pkg::ST_READ;
               end
            end
         end
         itora_pkg::ST_SIGN: begin
            if (sts.out_free) begin
               cmd.out_sign = 1'b1;
               state_in     = itora_pkg::ST_READ;
            end
         end
         itora_pkg::ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = itora_pkg::ST_EMIT;
         end
         itora_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_digit = 1'b1;
               state_in      = sts.cnt_zero ? itora_pkg::ST_IDLE : itora_pkg::ST_READ;
            end
         end
         itora_pkg::ST_BAD: begin
            if (sts.out_free) begin
               cmd.out_bad = 1'b1;
               state_in    = itora_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itora_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### src/itora_dp.sv
// itora_dp: magnitude/remainder registers, chunked long divider, digit stack
// memory and output register; depends on itora_pkg
module itora_dp (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [itora_pkg::RADIX_BITS-1:0]         radix,
   input  logic signed [itora_pkg::NUMBER_BITS-1:0] number,
   input  itora_pkg::itora_cmd_type                 cmd,
   output itora_pkg::itora_sts_type                 sts,
   input  logic                                     rsp_ready,
   output logic                                     rsp_valid,
   output logic [itora_pkg::CHAR_BITS-1:0]          rsp_character,
   output logic                                     rsp_is_last,
   output logic                                     rsp_bad_radix
);

   logic [itora_pkg::VALUE_BITS-1:0] mag_ff, mag_in;
   logic [itora_pkg::DIGIT_BITS-1:0] rem_ff, rem_in;
   logic                             neg_ff, neg_in;
   logic [itora_pkg::CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [itora_pkg::DIGIT_BITS-1:0] stack_ff [itora_pkg::VALUE_BITS];
   logic [itora_pkg::DIGIT_BITS-1:0] rd_data_ff;
   logic [itora_pkg::CNT_BITS-1:0]   rd_ptr;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [itora_pkg::CHAR_BITS-1:0]  rsp_char_ff, rsp_char_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic                             rsp_bad_ff, rsp_bad_in;

   logic [itora_pkg::VALUE_BITS-1:0] raw;
   logic [itora_pkg::VALUE_BITS-1:0] div_mag;
   logic [itora_pkg::DIGIT_BITS:0]   div_rem;

   assign raw = itora_pkg::VALUE_BITS'(number);

   // one chunk of restoring division, quotient bits shift in behind the dividend
   always_comb begin
      div_mag = mag_ff;
      div_rem = {1'b0, rem_ff};
      for (int j = 0; j < itora_pkg::CHUNK_BITS; j++) begin
         div_rem = {div_rem[itora_pkg::DIGIT_BITS-1:0], div_mag[itora_pkg::VALUE_BITS-1]};
         div_mag = {div_mag[itora_pkg::VALUE_BITS-2:0], 1'b0};
         if (div_rem >= {1'b0, radix}) begin
            div_rem    = div_rem - {1'b0, radix};
            div_mag[0] = 1'b1;
         end
      end
   end

   assign rd_ptr = cnt_ff - 1'b1;

   always_comb begin
      mag_in = mag_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         neg_in = raw[itora_pkg::VALUE_BITS-1];
         mag_in = raw[itora_pkg::VALUE_BITS-1] ? (~raw) + 1'b1 : raw;
         rem_in = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         mag_in = div_mag;
         rem_in = div_rem[itora_pkg::DIGIT_BITS-1:0];
         if (cmd.div_last) begin
            rem_in = '0;
            cnt_in = cnt_ff + 1'b1;
         end
      end else if (cmd.rd) begin
         cnt_in = rd_ptr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         neg_ff <= neg_in;
         cnt_ff <= cnt_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
   end

   // digit stack, least significant digit at entry zero
   always_ff @(posedge clock) begin
      if (cmd.div_step && cmd.div_last) begin
         stack_ff[cnt_ff[itora_pkg::ADDR_BITS-1:0]] <= div_rem[itora_pkg::DIGIT_BITS-1:0];
      end
      if (cmd.rd) begin
         rd_data_ff <= stack_ff[rd_ptr[itora_pkg::ADDR_BITS-1:0]];
      end
   end

   // output word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      if (cmd.out_sign) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = itora_pkg::CHAR_MINUS;
         rsp_last_in  = 1'b0;
         rsp_bad_in   = 1'b0;
      end else if (cmd.out_digit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = itora_pkg::digit_char(rd_data_ff);
         rsp_last_in  = (cnt_ff == '0);
         rsp_bad_in   = 1'b0;
      end else if (cmd.out_bad) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = itora_pkg::CHAR_NULL;
         rsp_last_in  = 1'b1;
         rsp_bad_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_is_last   = rsp_last_ff;
   assign rsp_bad_radix = rsp_bad_ff;

   assign sts.radix_bad = !(radix inside {[itora_pkg::RADIX_MIN:itora_pkg::RADIX_MAX]});
   assign sts.quot_zero = (div_mag == '0);
   assign sts.negative  = neg_ff;
   assign sts.cnt_zero  = (cnt_ff == '0);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

### src/integer_to_radix_ascii.sv
// integer_to_radix_ascii: top level of the integer to radix text converter
// depends on itora_pkg, itora_if, itora_ctrl and itora_dp
//
// usage
//   req channel: one word carries a signed 32-bit number; taken when valid and
//     ready are both high, ready is high only while the block is idle
//   rsp channel: one word per text character, most significant first, a
//     leading '-' for negative values, is_last on the final character
//   csr port: a single register, radix (byte address 0, 6 bits, reset 10);
//     radix outside 2..36 makes the next number give one word with
//     bad_radix set, character 0 and is_last set
// timing
//   the divider does 8 quotient bits a cycle, working through the magnitude in
//   8-bit chunks for each digit; each character then takes a stack read and an
//   output load, and a negative number adds the '-' as its own output load;
//   the longest item is the most negative value at base 2; an invalid radix
//   item skips the divider and goes straight to its error word
// stalls and reset
//   output is one registered word; a stalled receiver holds the sequencer in
//   place, nothing is lost; the last word may still wait while the next
//   number is taken
//   synchronous reset empties the output and returns to idle, radix goes to 10
module integer_to_radix_ascii (
   input  logic                                 clock,
   input  logic                                 reset,
   itora_req_if.sink                            req,
   itora_rsp_if.source                          rsp,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [itora_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [itora_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [itora_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   logic [itora_pkg::RADIX_BITS-1:0] radix_ff, radix_in;
   logic                             reg_hit;
   itora_pkg::itora_cmd_type         cmd;
   itora_pkg::itora_sts_type         sts;

   // register decode ignores the byte offset within the word
   assign reg_hit    = (csr_paddr[itora_pkg::CSR_ADDR_BITS-1:2] == itora_pkg::REG_RADIX);
   assign csr_pready = 1'b1;

   always_comb begin
      radix_in = radix_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         radix_in = csr_pwdata[itora_pkg::RADIX_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= itora_pkg::RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   // unmapped addresses read as zero
   assign csr_prdata = reg_hit ? itora_pkg::CSR_DATA_BITS'(radix_ff) : '0;

   // sequencer
   itora_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // divider, digit stack and output word register
   itora_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .radix         (radix_ff),
      .number        (req.number),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_ready     (rsp.ready),
      .rsp_valid     (rsp.valid),
      .rsp_character (rsp.character),
      .rsp_is_last   (rsp.is_last),
      .rsp_bad_radix (rsp.bad_radix)
   );

endmodule

### verif/integer_to_radix_ascii_tb.sv
`timescale 1ns / 100ps
// integer_to_radix_ascii_tb: self-checking bench for the integer to radix text converter
// depends on itora_pkg, itora_if and integer_to_radix_ascii
module integer_to_radix_ascii_tb;

   // bench timing
   localparam int SETTLE_CYCLES   = 4;     // idle margin before touching the radix register
   localparam int END_CYCLES      = 200;   // covers the longest item, the most negative value at base 2
   localparam int WATCHDOG_CYCLES = 2000;  // cycles with no word moving on any port
   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_ITEMS     = 13;

   // csr map: one register per 4 bytes, only index 0 exists
   localparam logic [itora_pkg::CSR_ADDR_BITS-1:0] ADDR_RADIX =
      {itora_pkg::REG_RADIX, 2'b00};
   localparam logic [itora_pkg::CSR_ADDR_BITS-1:0] ADDR_SPARE =
      {itora_pkg::REG_RADIX + 1'b1, 2'b00};

   localparam string DIGIT_SET = "0123456789abcdefghijklmnopqrstuvwxyz";

   // one character word as it leaves the block
   typedef struct packed {
      logic [itora_pkg::CHAR_BITS-1:0] character;
      logic                            is_last;
      logic                            bad_radix;
   } text_word_type;

   // directed script: radix writes, numbers checked by the predictor, numbers whose
   // text is typed in, and numbers sent under an out-of-range radix
   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_NUMBER,
      ROW_NUMBER_TYPED,
      ROW_NUMBER_BAD
   } row_kind_type;

   typedef struct packed {
      row_kind_type                        kind;
      logic [itora_pkg::CSR_ADDR_BITS-1:0] addr;
      logic [itora_pkg::CSR_DATA_BITS-1:0] value;
   } script_row_type;

   localparam int SCRIPT_ROWS = 31;

   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      // reset radix is 10
      '{ROW_NUMBER_TYPED, ADDR_RADIX, 32'd0},
      '{ROW_NUMBER_TYPED, ADDR_RADIX, 32'h7fff_ffff},
      '{ROW_NUMBER_TYPED, ADDR_RADIX, 32'h8000_0000},
      '{ROW_NUMBER_TYPED, ADDR_RADIX, 32'hffff_ffff},
      '{ROW_NUMBER,       ADDR_RADIX, 32'd123456789},
      // base 2: most negative value gives the longest text
      '{ROW_CSR,          ADDR_RADIX, 32'd2},
      '{ROW_NUMBER_TYPED, ADDR_RADIX, 32'h8000_0000},
      '{ROW_NUMBER_TYPED, ADDR_RADIX, 32'hffff_ffff},
      '{ROW_NUMBER,       ADDR_RADIX, 32'h7fff_ffff},
      // base 36: top digit 'z'
      '{ROW_CSR,          ADDR_RADIX, 32'd36},
      '{ROW_NUMBER_TYPED, ADDR_RADIX, 32'h7fff_ffff},
      '{ROW_NUMBER_TYPED, ADDR_RADIX, 32'h8000_0000},
      '{ROW_NUMBER_TYPED, ADDR_RADIX, 32'd35},
      '{ROW_NUMBER_TYPED, ADDR_RADIX, 32'd36},
      // out-of-range radix on both sides of the valid window
      '{ROW_CSR,          ADDR_RADIX, 32'd37},
      '{ROW_NUMBER_BAD,   ADDR_RADIX, 32'd5},
      '{ROW_CSR,          ADDR_RADIX, 32'd0},
      '{ROW_NUMBER_BAD,   ADDR_RADIX, 32'hffff_fff9},
      '{ROW_CSR,          ADDR_RADIX, 32'd1},
      '{ROW_NUMBER_BAD,   ADDR_RADIX, 32'd0},
      '{ROW_CSR,          ADDR_RADIX, 32'd63},
      '{ROW_NUMBER_BAD,   ADDR_RADIX, 32'h7fff_ffff},
      // base 16, then a write to a missing register that must leave it alone
      '{ROW_CSR,          ADDR_RADIX, 32'd16},
      '{ROW_CSR,          ADDR_SPARE, 32'd3},
      '{ROW_NUMBER_TYPED, ADDR_RADIX, 32'd255},
      '{ROW_NUMBER_TYPED, ADDR_RADIX, 32'hffff_ff00},
      // base 3, alternating bit patterns, then base 10
      '{ROW_CSR,          ADDR_RADIX, 32'd3},
      '{ROW_NUMBER,       ADDR_RADIX, 32'haaaa_aaaa},
      '{ROW_NUMBER,       ADDR_RADIX, 32'h5555_5555},
      '{ROW_CSR,          ADDR_RADIX, 32'd10},
      '{ROW_NUMBER,       ADDR_RADIX, 32'hdead_beef}
   };

   // typed text for the ROW_NUMBER_TYPED rows, same order as the script
   // base 2 most negative: '-', a one, then 31 zeros
   string script_text [SCRIPT_ROWS] = '{
      "0", "2147483647", "-2147483648", "-1", "",
      "", {"-1", "0000000000", "0000000000", "0000000000", "0"}, "-1", "",
      "", "zik0zj", "-zik0zk", "z", "10",
      "", "", "", "", "", "", "", "",
      "", "", "ff", "-100",
      "", "", "", "", ""
   };

   logic clock;
   logic reset;

   logic                                csr_psel;
   logic                                csr_penable;
   logic                                csr_pwrite;
   logic [itora_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [itora_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [itora_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                                csr_pready;

   itora_req_if req_chan ();
   itora_rsp_if rsp_chan ();

   integer_to_radix_ascii dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state: radix as the block should hold it, and the characters still owed
   logic [itora_pkg::RADIX_BITS-1:0] radix_setting = itora_pkg::RADIX_RESET;
   text_word_type                    chars_due [$];
   text_word_type                    word_due;

   int error_count      = 0;
   int numbers_taken    = 0;
   int chars_seen       = 0;
   int radix_writes     = 0;
   int bad_radix_writes = 0;
   int spare_writes     = 0;
   int quiet_cycles     = 0;
   int stall_tick       = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // predictor: text of a number in the given base, most significant first, or error word
   function automatic void render_number(input logic [itora_pkg::NUMBER_BITS-1:0] value,
                                         input logic [itora_pkg::RADIX_BITS-1:0] base);
      logic [itora_pkg::NUMBER_BITS-1:0] mag;
      logic [itora_pkg::DIGIT_BITS-1:0]  digits [itora_pkg::VALUE_BITS];
      int                                n;
      byte                               c;
      text_word_type                     w;
      if (base < itora_pkg::RADIX_MIN || base > itora_pkg::RADIX_MAX) begin
         w = '{character: itora_pkg::CHAR_NULL, is_last: 1'b1, bad_radix: 1'b1};
         chars_due.push_back(w);
         return;
      end
      // two's complement negate is exact for the most negative value when read unsigned
      mag = value[itora_pkg::NUMBER_BITS-1] ? -value : value;
      if (value[itora_pkg::NUMBER_BITS-1]) begin
         w = '{character: itora_pkg::CHAR_MINUS, is_last: 1'b0, bad_radix: 1'b0};
         chars_due.push_back(w);
      end
      n = 0;
      do begin
         digits[n] = itora_pkg::DIGIT_BITS'(mag % base);
         mag       = mag / base;
         n++;
      end while (mag != 0 && n < itora_pkg::VALUE_BITS);
      for (int i = n - 1; i >= 0; i--) begin
         c = DIGIT_SET[digits[i]];
         w = '{character: c[itora_pkg::CHAR_BITS-1:0], is_last: (i == 0), bad_radix: 1'b0};
         chars_due.push_back(w);
      end
   endfunction

   // typed-in text for the directed rows
   function automatic void push_text(input string text);
      byte           c;
      text_word_type w;
      for (int i = 0; i < text.len(); i++) begin
         c = text[i];
         w = '{character: c[itora_pkg::CHAR_BITS-1:0], is_last: (i == text.len() - 1),
               bad_radix: 1'b0};
         chars_due.push_back(w);
      end
   endfunction

   // random number shaped toward the interesting corners of the given base
   function automatic logic [itora_pkg::NUMBER_BITS-1:0] pick_number(
         input logic [itora_pkg::RADIX_BITS-1:0] base);
      logic [63:0]                       power;
      logic [itora_pkg::NUMBER_BITS-1:0] value;
      int unsigned                       b;
      b = (base >= itora_pkg::RADIX_MIN && base <= itora_pkg::RADIX_MAX) ? base : 10;
      case ($urandom_range(0, 5))
         0: value = $urandom();
         1: value = $urandom_range(0, 1500);
         2: begin
            case ($urandom_range(0, 5))
               0:       value = '0;
               1:       value = 32'h7fff_ffff;
               2:       value = 32'h8000_0000;
               3:       value = 32'd1;
               4:       value = b;
               default: value = b - 1;
            endcase
         end
         3: begin
            // around a power of the base, where the digit count steps
            power = 64'd1;
            repeat ($urandom_range(1, 31)) begin
               if (power * b <= 64'h8000_0000) power = power * b;
            end
            value = power[itora_pkg::NUMBER_BITS-1:0] + $urandom_range(0, 2) - 1;
         end
         default: value = $urandom() >> $urandom_range(0, 31);
      endcase
      if (value != 32'h8000_0000 && $urandom_range(0, 1) == 1) value = -value;
      return value;
   endfunction

   // one apb transfer: setup, access until pready, then back to idle
   task automatic csr_access(input logic write,
                             input logic [itora_pkg::CSR_ADDR_BITS-1:0] addr,
                             input logic [itora_pkg::CSR_DATA_BITS-1:0] data,
                             output logic [itora_pkg::CSR_DATA_BITS-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // register write, then read the radix back and hold it against the predictor
   task automatic write_csr(input logic [itora_pkg::CSR_ADDR_BITS-1:0] addr,
                            input logic [itora_pkg::CSR_DATA_BITS-1:0] data);
      logic [itora_pkg::CSR_DATA_BITS-1:0] readback;
      csr_access(1'b1, addr, data, readback);
      if (addr[itora_pkg::CSR_ADDR_BITS-1:2] == itora_pkg::REG_RADIX) begin
         radix_setting = data[itora_pkg::RADIX_BITS-1:0];
         radix_writes++;
         if (radix_setting < itora_pkg::RADIX_MIN || radix_setting > itora_pkg::RADIX_MAX) begin
            bad_radix_writes++;
         end
      end else begin
         spare_writes++;
      end
      csr_access(1'b0, ADDR_RADIX, '0, readback);
      if (readback !== itora_pkg::CSR_DATA_BITS'(radix_setting)) begin
         $error("radix: expected %0d, got %0d", radix_setting, readback);
         error_count++;
      end
   endtask

   // offer one word and hold it until the block takes it; valid stays high afterward
   task automatic send_number(input logic [itora_pkg::NUMBER_BITS-1:0] value);
      req_chan.valid  <= 1'b1;
      req_chan.number <= value;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // sender goes idle, with junk on the data lines
   task automatic sender_gap(input int cycles);
      req_chan.valid  <= 1'b0;
      req_chan.number <= $urandom();
      repeat (cycles) @(posedge clock);
   endtask

   // stop sending until every owed character has come, then let the block settle
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      // sampled at the falling edge so the checker's pop at the rising edge is settled
      do @(negedge clock); while (chars_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver stall pattern, chosen by bits 11:10 of a free-running tick:
   // always ready, mostly ready, periodic stalls, mostly stalled
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      case (stall_tick[11:10])
         2'd0:    rsp_chan.ready <= 1'b1;
         2'd1:    rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         2'd2:    rsp_chan.ready <= ((stall_tick % 7) > 2);
         default: rsp_chan.ready <= ($urandom_range(0, 9) < 4);
      endcase
   end

   // checker and watchdog: every accepted character word against the oldest one owed
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) numbers_taken++;
         if (rsp_chan.valid && rsp_chan.ready) begin
            chars_seen++;
            if (chars_due.size() == 0) begin
               $error("unexpected word: character %h, is_last %b, bad_radix %b",
                      rsp_chan.character, rsp_chan.is_last, rsp_chan.bad_radix);
               error_count++;
            end else begin
               word_due = chars_due.pop_front();
               if (rsp_chan.character !== word_due.character) begin
                  $error("character: expected %h, got %h",
                         word_due.character, rsp_chan.character);
                  error_count++;
               end
               if (rsp_chan.is_last !== word_due.is_last) begin
                  $error("is_last: expected %b, got %b", word_due.is_last, rsp_chan.is_last);
                  error_count++;
               end
               if (rsp_chan.bad_radix !== word_due.bad_radix) begin
                  $error("bad_radix: expected %b, got %b",
                         word_due.bad_radix, rsp_chan.bad_radix);
                  error_count++;
               end
            end
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             csr_psel) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_CYCLES);
            $display("integer_to_radix_ascii_tb: done, errors");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      logic [itora_pkg::RADIX_BITS-1:0]  base;
      logic [itora_pkg::NUMBER_BITS-1:0] value;
      int                                burst_left;
      reset           <= 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.number <= '0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: back to back words, stalls come from the receiver only
      for (int row = 0; row < SCRIPT_ROWS; row++) begin
         case (SCRIPT[row].kind)
            ROW_CSR: begin
               wait_for_drain();
               write_csr(SCRIPT[row].addr, SCRIPT[row].value);
            end
            ROW_NUMBER: begin
               render_number(SCRIPT[row].value, radix_setting);
               send_number(SCRIPT[row].value);
            end
            ROW_NUMBER_TYPED: begin
               push_text(script_text[row]);
               send_number(SCRIPT[row].value);
            end
            default: begin
               // out-of-range radix: one error word
               chars_due.push_back(text_word_type'{character: itora_pkg::CHAR_NULL,
                                                   is_last: 1'b1, bad_radix: 1'b1});
               send_number(SCRIPT[row].value);
            end
         endcase
      end

      // random part: one radix per phase, written while the block is idle
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_drain();
         if (phase == 0) begin
            base = itora_pkg::RADIX_MIN;
         end else if (phase == 1) begin
            base = itora_pkg::RADIX_MAX;
         end else if ($urandom_range(0, 5) == 0) begin
            base = ($urandom_range(0, 2) == 0) ?
                   itora_pkg::RADIX_BITS'($urandom_range(0, 1)) :
                   itora_pkg::RADIX_BITS'($urandom_range(37, 63));
         end else begin
            base = itora_pkg::RADIX_BITS'($urandom_range(2, 36));
         end
         // junk above the 6 register bits must be dropped
         write_csr(ADDR_RADIX, ($urandom() & ~32'h3f) | itora_pkg::CSR_DATA_BITS'(base));
         if ($urandom_range(0, 2) == 0) write_csr(ADDR_SPARE, $urandom());

         burst_left = 0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // now and then hold off until the block has nothing owed
            if ((phase == 3 && i == 7) || $urandom_range(0, 29) == 0) wait_for_drain();
            // every fourth phase runs without sender gaps
            if (phase % 4 != 1) begin
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 8);
                  sender_gap($urandom_range(1, 6));
               end
               burst_left--;
            end
            value = pick_number(radix_setting);
            render_number(value, radix_setting);
            send_number(value);
         end
      end

      // drain, then give the block its longest item time to show any stray word
      wait_for_drain();
      repeat (END_CYCLES) @(posedge clock);
      if (chars_due.size() != 0) begin
         $error("%0d characters never arrived", chars_due.size());
         error_count++;
      end

      $display("%0d numbers converted to %0d characters, %0d radix writes (%0d out of range)",
               numbers_taken, chars_seen, radix_writes, bad_radix_writes);
      $display("sender bursts and drains, four receiver stall patterns, %0d spare writes",
               spare_writes);
      if (error_count == 0) begin
         $display("integer_to_radix_ascii_tb: done, clean");
      end else begin
         $display("integer_to_radix_ascii_tb: done, errors");
      end
      $finish;
   end

endmodule

### filelist.f
src/itora_pkg.sv
src/itora_if.sv
src/itora_ctrl.sv
src/itora_dp.sv
src/integer_to_radix_ascii.sv
verif/integer_to_radix_ascii_tb.sv
